@@ src/ordered_key_list_engine_assert.svh @@
// Assertion macros for the ordered key list engine.
// Used by the top level; needs i_clk and i_rst_n in scope.
`ifndef ORDERED_KEY_LIST_ENGINE_ASSERT_SVH
`define ORDERED_KEY_LIST_ENGINE_ASSERT_SVH
`ifndef SYNTH
`define OKLE_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("okle assertion failed");
`define OKLE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("okle assertion failed");
`else
`define OKLE_ASSERT_SAME(lbl, ante, cons)
`define OKLE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ src/okle_pkg.sv @@
// Shared constants and codes for the ordered key list engine.
// No dependencies.
package okle_pkg;
    localparam int CAPACITY = 32;
    localparam int AW       = $clog2(CAPACITY);
    localparam int DEPTH    = 2 ** AW;
    localparam int CW       = $clog2(CAPACITY + 1);
    localparam int KW       = 32;

    localparam logic [2:0] REQ_INSERT      = 3'd0;
    localparam logic [2:0] REQ_DELETE_KEY  = 3'd1;
    localparam logic [2:0] REQ_DELETE_HEAD = 3'd2;
    localparam logic [2:0] REQ_DELETE_TAIL = 3'd3;
    localparam logic [2:0] REQ_LIST        = 3'd4;

    localparam logic [2:0] ST_DONE  = 3'd0;
    localparam logic [2:0] ST_FULL  = 3'd1;
    localparam logic [2:0] ST_NONE  = 3'd2;
    localparam logic [2:0] ST_ENTRY = 3'd3;
    localparam logic [2:0] ST_EMPTY = 3'd4;

    typedef logic signed [KW-1:0] t_key;
endpackage

@@ src/okle_if.sv @@
// Handshake channels of the ordered key list engine: request and result.
// Depends on okle_pkg.
interface okle_req_if import okle_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [2:0] req_type;
    t_key       key_value;
    modport source (output valid, req_type, key_value, input ready);
    modport sink   (input valid, req_type, key_value, output ready);
endinterface

interface okle_rsp_if import okle_pkg::*; ();
    logic       valid;
    logic       ready;
    t_key       out_key;
    logic [2:0] status;
    logic       last;
    modport source (output valid, out_key, status, last, input ready);
    modport sink   (input valid, out_key, status, last, output ready);
endinterface

@@ src/okle_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module okle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ src/ordered_key_list_engine.sv @@
// Ordered key list engine top level: request decode, list sequencer, result register.
// Depends on okle_pkg, okle_if, okle_ram and ordered_key_list_engine_assert.svh.
//
//   channel   dir  payload                    handshake
//   i_req     in   req_type, key_value        valid/ready
//   o_rsp     out  out_key, status, last      valid/ready
//
// Keys sit in one RAM as a ring; a head pointer and a count give their order.
// Insert, delete head/tail and list-empty finish in the accept cycle.
// Delete by key: read and compare each key, then move each later key back one slot.
// List: read each key from RAM, then emit it, waiting while the result is stalled.
// Synchronous active-low reset empties the list; no clearing pass is needed.
`include "ordered_key_list_engine_assert.svh"
module ordered_key_list_engine import okle_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    okle_req_if.sink   i_req,
    okle_rsp_if.source o_rsp
);
    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SCAN_RD = 3'd1;
    localparam logic [2:0] S_SCAN_CK = 3'd2;
    localparam logic [2:0] S_SH_RD   = 3'd3;
    localparam logic [2:0] S_SH_WR   = 3'd4;
    localparam logic [2:0] S_LIST_RD = 3'd5;
    localparam logic [2:0] S_LIST_CK = 3'd6;

    logic [2:0]    r_state, n_state;
    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx, n_idx;
    t_key          r_key, n_key;
    logic          r_ovalid, n_ovalid;
    t_key          r_okey, n_okey;
    logic [2:0]    r_ostat, n_ostat;
    logic          r_olast, n_olast;

    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    t_key          ram_wdata, ram_rdata;
    logic          out_free, accept;
    logic [CW-1:0] idx_p1, idx_p2;

    okle_ram #(.WIDTH(KW), .DEPTH(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign out_free    = !r_ovalid || o_rsp.ready;
    assign i_req.ready = (r_state == S_IDLE) && out_free;
    assign accept      = i_req.valid && i_req.ready;
    assign idx_p1      = r_idx + CW'(1);
    assign idx_p2      = r_idx + CW'(2);

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_count   = r_count;
        n_idx     = r_idx;
        n_key     = r_key;
        n_ovalid  = r_ovalid && !o_rsp.ready;
        n_okey    = r_okey;
        n_ostat   = r_ostat;
        n_olast   = r_olast;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_waddr = r_head - AW'(1);
        ram_wdata = i_req.key_value;
        ram_raddr = r_head + r_idx[AW-1:0];

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_ovalid = 1'b1;
                    n_okey   = '0;
                    n_olast  = 1'b1;
                    n_ostat  = ST_NONE;
                    n_idx    = '0;
                    n_key    = i_req.key_value;
                    case (i_req.req_type)
                        REQ_INSERT: begin
                            if (r_count == CW'(CAPACITY)) begin
                                n_ostat = ST_FULL;
                            end else begin
                                ram_we  = 1'b1;
                                n_head  = r_head - AW'(1);
                                n_count = r_count + CW'(1);
                                n_ostat = ST_DONE;
                            end
                        end
                        REQ_DELETE_KEY: begin
                            if (r_count != '0) begin
                                n_ovalid = 1'b0;
                                n_state  = S_SCAN_RD;
                            end
                        end
                        REQ_DELETE_HEAD: begin
                            if (r_count != '0) begin
                                n_head  = r_head + AW'(1);
                                n_count = r_count - CW'(1);
                                n_ostat = ST_DONE;
                            end
                        end
                        REQ_DELETE_TAIL: begin
                            if (r_count != '0) begin
                                n_count = r_count - CW'(1);
                                n_ostat = ST_DONE;
                            end
                        end
                        REQ_LIST: begin
                            if (r_count == '0) begin
                                n_ostat = ST_EMPTY;
                            end else begin
                                n_ovalid = 1'b0;
                                n_state  = S_LIST_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN_RD: begin
                ram_re  = 1'b1;
                n_state = S_SCAN_CK;
            end
            S_SCAN_CK: begin
                // slot is free here: nothing emitted since the request was taken
                if (ram_rdata == r_key) begin
                    if (idx_p1 < r_count) begin
                        n_state = S_SH_RD;
                    end else begin
                        n_count  = r_count - CW'(1);
                        n_ovalid = 1'b1;
                        n_okey   = '0;
                        n_ostat  = ST_DONE;
                        n_olast  = 1'b1;
                        n_state  = S_IDLE;
                    end
                end else if (idx_p1 == r_count) begin
                    n_ovalid = 1'b1;
                    n_okey   = '0;
                    n_ostat  = ST_NONE;
                    n_olast  = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_idx   = idx_p1;
                    n_state = S_SCAN_RD;
                end
            end
            S_SH_RD: begin
                ram_re    = 1'b1;
                ram_raddr = r_head + idx_p1[AW-1:0];
                n_state   = S_SH_WR;
            end
            S_SH_WR: begin
                // close the gap: key at idx+1 moves to idx
                ram_we    = 1'b1;
                ram_waddr = r_head + r_idx[AW-1:0];
                ram_wdata = ram_rdata;
                n_idx     = idx_p1;
                if (idx_p2 < r_count) begin
                    n_state = S_SH_RD;
                end else begin
                    n_count  = r_count - CW'(1);
                    n_ovalid = 1'b1;
                    n_okey   = '0;
                    n_ostat  = ST_DONE;
                    n_olast  = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_LIST_RD: begin
                ram_re  = 1'b1;
                n_state = S_LIST_CK;
            end
            S_LIST_CK: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_okey   = ram_rdata;
                    n_ostat  = ST_ENTRY;
                    n_olast  = (idx_p1 == r_count);
                    n_idx    = idx_p1;
                    n_state  = (idx_p1 == r_count) ? S_IDLE : S_LIST_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_count  <= '0;
            r_idx    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_count  <= n_count;
            r_idx    <= n_idx;
            r_ovalid <= n_ovalid;
        end
        r_key   <= n_key;
        r_okey  <= n_okey;
        r_ostat <= n_ostat;
        r_olast <= n_olast;
    end

    assign o_rsp.valid   = r_ovalid;
    assign o_rsp.out_key = r_okey;
    assign o_rsp.status  = r_ostat;
    assign o_rsp.last    = r_olast;

    `OKLE_ASSERT_SAME(a_count_cap, 1'b1, r_count <= CW'(CAPACITY))
    `OKLE_ASSERT_SAME(a_ready_idle, i_req.ready, r_state == S_IDLE)
    `OKLE_ASSERT_NEXT(a_insert_grows,
        accept && i_req.req_type == REQ_INSERT && r_count != CW'(CAPACITY),
        r_count == $past(r_count) + CW'(1))
    `OKLE_ASSERT_SAME(a_scan_in_range,
        r_state == S_SCAN_CK || r_state == S_LIST_CK, r_idx < r_count)
endmodule

@@ test/tb.sv @@
// Self-checking testbench for ordered_key_list_engine: directed and random requests.
// Depends on okle_pkg, okle_if and the engine RTL.
`timescale 1ns / 100ps
module tb;
    import okle_pkg::*;

    typedef struct packed {
        t_key       key;
        logic [2:0] status;
        logic       last;
    } t_rsp;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always #5 i_clk = ~i_clk;

    okle_req_if req_ch ();
    okle_rsp_if rsp_ch ();

    ordered_key_list_engine uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    // predictor state
    t_key       list_keys[$];
    t_rsp       expected_rsps[$];
    int         errors = 0;
    int         rsp_seen = 0;
    int         req_sent = 0;
    int         idle_cycles = 0;
    int         hold_off = 0;
    int         rsp_wait = 0;
    bit         rand_ready = 1'b0;

    initial begin
        req_ch.valid = 1'b0;
        req_ch.req_type = REQ_INSERT;
        req_ch.key_value = '0;
        rsp_ch.ready = 1'b0;
    end

    function automatic t_rsp mk(t_key k, logic [2:0] s, logic l);
        t_rsp r;
        r.key = k;
        r.status = s;
        r.last = l;
        return r;
    endfunction

    // work out the results a request causes and update the model list
    function automatic void predict_list(logic [2:0] rt, t_key kv);
        int pos;
        pos = -1;
        case (rt)
            REQ_INSERT: begin
                if (list_keys.size() >= CAPACITY) begin
                    expected_rsps.push_back(mk('0, ST_FULL, 1'b1));
                end else begin
                    list_keys.push_front(kv);
                    expected_rsps.push_back(mk('0, ST_DONE, 1'b1));
                end
            end
            REQ_DELETE_KEY: begin
                foreach (list_keys[i])
                    if (pos < 0 && list_keys[i] == kv) pos = i;
                if (pos >= 0) begin
                    list_keys.delete(pos);
                    expected_rsps.push_back(mk('0, ST_DONE, 1'b1));
                end else begin
                    expected_rsps.push_back(mk('0, ST_NONE, 1'b1));
                end
            end
            REQ_DELETE_HEAD, REQ_DELETE_TAIL: begin
                if (list_keys.size() == 0) begin
                    expected_rsps.push_back(mk('0, ST_NONE, 1'b1));
                end else begin
                    if (rt == REQ_DELETE_HEAD) void'(list_keys.pop_front());
                    else void'(list_keys.pop_back());
                    expected_rsps.push_back(mk('0, ST_DONE, 1'b1));
                end
            end
            REQ_LIST: begin
                if (list_keys.size() == 0)
                    expected_rsps.push_back(mk('0, ST_EMPTY, 1'b1));
                else
                    foreach (list_keys[i])
                        expected_rsps.push_back(mk(list_keys[i], ST_ENTRY,
                            i == list_keys.size() - 1));
            end
            default: expected_rsps.push_back(mk('0, ST_NONE, 1'b1));
        endcase
    endfunction

    // valid stays up after an accept until the next call drops it or replaces the item
    task automatic send_req(logic [2:0] rt, t_key kv, bit with_gap);
        int gap;
        gap = with_gap ? $urandom_range(0, 15) : 0;
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.req_type <= rt;
        req_ch.key_value <= kv;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        predict_list(rt, kv);
        req_sent++;
    endtask

    // receiver: drawn wait per item, or a long hold-off
    always @(posedge i_clk) begin
        int w;
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
            rsp_wait <= 0;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            rsp_ch.ready <= 1'b0;
        end else if (rsp_ch.valid && rsp_ch.ready) begin
            if (rand_ready) begin
                w = $urandom_range(0, 15);
                rsp_wait <= w;
                rsp_ch.ready <= (w == 0);
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end else if (rsp_wait > 0) begin
            rsp_wait <= rsp_wait - 1;
            rsp_ch.ready <= (rsp_wait == 1);
        end else begin
            rsp_ch.ready <= 1'b1;
        end
    end

    // result checker and watchdog
    always @(posedge i_clk) begin
        t_rsp e;
        if (i_rst_n) begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles > 2000) begin
                $display("Some tests failed");
                $finish;
            end
            if (rsp_ch.valid && rsp_ch.ready) begin
                rsp_seen++;
                if (expected_rsps.size() == 0) begin
                    $error("unexpected result: key %0d status %0d", rsp_ch.out_key,
                        rsp_ch.status);
                    errors++;
                end else begin
                    e = expected_rsps.pop_front();
                    if (rsp_ch.out_key !== e.key) begin
                        $error("out_key exp %0d got %0d", e.key, rsp_ch.out_key);
                        errors++;
                    end
                    if (rsp_ch.status !== e.status) begin
                        $error("status exp %0d got %0d", e.status, rsp_ch.status);
                        errors++;
                    end
                    if (rsp_ch.last !== e.last) begin
                        $error("last exp %0d got %0d", e.last, rsp_ch.last);
                        errors++;
                    end
                end
            end
        end
    end

    function automatic t_key rand_key();
        return t_key'($urandom);
    endfunction

    task automatic test_directed();
        send_req(REQ_LIST, '0, 1'b0);
        send_req(REQ_DELETE_HEAD, '0, 1'b0);
        send_req(REQ_DELETE_TAIL, '0, 1'b0);
        send_req(REQ_DELETE_KEY, 32'sd5, 1'b0);
        send_req(REQ_INSERT, 32'sh7fffffff, 1'b0);
        send_req(REQ_INSERT, 32'sh80000000, 1'b0);
        send_req(REQ_INSERT, 32'sd0, 1'b0);
        send_req(REQ_INSERT, -32'sd1, 1'b0);
        send_req(REQ_INSERT, 32'sd0, 1'b0);
        send_req(REQ_LIST, '1, 1'b0);
        send_req(REQ_DELETE_KEY, 32'sd0, 1'b0);
        send_req(REQ_DELETE_KEY, 32'sd12345, 1'b0);
        send_req(REQ_DELETE_HEAD, '0, 1'b0);
        send_req(REQ_DELETE_TAIL, '0, 1'b0);
        send_req(3'd5, '1, 1'b0);
        send_req(3'd6, '0, 1'b0);
        send_req(3'd7, '0, 1'b0);
        send_req(REQ_LIST, '0, 1'b0);
    endtask

    // fill to capacity, then two inserts past full and a list
    task automatic test_full();
        while (list_keys.size() < CAPACITY) send_req(REQ_INSERT, rand_key(), 1'b0);
        send_req(REQ_INSERT, 32'sd1, 1'b0);
        send_req(REQ_INSERT, 32'sd2, 1'b0);
        send_req(REQ_LIST, '0, 1'b0);
    endtask

    // receiver stalls long while requests keep coming
    task automatic test_backpressure();
        hold_off <= 300;
        repeat (6) send_req(REQ_LIST, '0, 1'b0);
        repeat (4) send_req(REQ_DELETE_TAIL, '0, 1'b0);
    endtask

    task automatic test_random();
        int rt;
        t_key kv;
        rand_ready = 1'b1;
        repeat (60) begin
            rt = $urandom_range(0, 99);
            if (rt < 35) rt = REQ_INSERT;
            else if (rt < 55) rt = REQ_DELETE_KEY;
            else if (rt < 65) rt = REQ_DELETE_HEAD;
            else if (rt < 75) rt = REQ_DELETE_TAIL;
            else if (rt < 95) rt = REQ_LIST;
            else rt = $urandom_range(5, 7);
            kv = rand_key();
            // small key pool so deletes often hit
            if ($urandom_range(0, 3) != 0) kv = t_key'($urandom_range(0, 7)) - 4;
            if (rt == REQ_DELETE_KEY && list_keys.size() > 0 && $urandom_range(0, 1))
                kv = list_keys[$urandom_range(0, list_keys.size() - 1)];
            send_req(rt[2:0], kv, 1'b1);
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_full();
        test_backpressure();
        test_random();
        req_ch.valid <= 1'b0;
        while (expected_rsps.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        $display("Sent %0d requests, checked %0d results, list filled to %0d keys.",
            req_sent, rsp_seen, CAPACITY);
        if (errors == 0 && expected_rsps.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

@@ files.f @@
+incdir+src
src/okle_pkg.sv
src/okle_if.sv
src/okle_ram.sv
src/ordered_key_list_engine.sv
test/tb.sv
